// ----- rtl/cartridge_bank_mapper_assert.svh -----
// assertion macros for the cartridge bank mapper
// expects clk and rst_n to be visible where the macros are used
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

// checked only outside reset
`define CBM_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cbm_pkg.sv -----
// types and constants for the cartridge bank mapper
// no dependencies
package cbm_pkg;

    typedef enum logic [1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_ROM_READ  = 2'd1,
        CMD_RAM_WRITE = 2'd2,
        CMD_RAM_READ  = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        MK_NONE  = 3'd0,
        MK_MBC1  = 3'd1,
        MK_MBC1M = 3'd2,
        MK_MBC2  = 3'd3,
        MK_MBC3  = 3'd4,
        MK_MBC5  = 3'd5
    } mapper_kind_t;

    typedef enum logic [1:0] {
        CFG_MAPPER_KIND   = 2'd0,
        CFG_ROM_SIZE_CODE = 2'd1,
        CFG_RAM_SIZE_CODE = 2'd2
    } cfg_index_t;

    localparam logic [3:0] ROM_CODE_MAX   = 4'd8;
    localparam logic [3:0] ENABLE_NIBBLE  = 4'hA;
    localparam logic [3:0] MBC3_RAM_BANKS = 4'd7;
    localparam logic [8:0] ROM_BANK_RESET = 9'd1;
    localparam logic [7:0] MBC2_DATA_ONES = 8'hF0;
    localparam logic [7:0] OPEN_BUS_MASK  = 8'hFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [14:0] address;
        logic [7:0]  data;
    } in_item_t;

    typedef struct packed {
        logic [22:0] rom_address;
        logic [14:0] ram_address;
        logic        ram_select;
        logic        ram_write_strobe;
        logic [7:0]  write_data;
        logic [7:0]  read_or_mask;
    } out_item_t;

endpackage

// ----- rtl/cartridge_bank_mapper.sv -----
// cartridge bank mapper top level: register stage, bank state, address translation
// depends on cbm_pkg and cartridge_bank_mapper_assert.svh
//
// usage:
//   in channel (in_valid/in_ready/in_item) carries one bus transaction per cycle:
//   a mapper register write, a ROM read, or an external RAM write or read.
//   out channel (out_valid/out_ready/out_item) returns exactly one result per
//   transaction, in order, with ROM/RAM addresses, select, strobe, write data
//   and the OR mask for read data.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes mapper_kind,
//   rom_size_code and ram_size_code; cfg_ready is always high, write only idle.
//   a transaction accepted passes the input register, then the result register.
//   throughput: one transaction per cycle while out_ready stays high, set by the
//   input register and the result register each taking a new entry every cycle.
//   a stalled receiver holds the result register; the input register still
//   takes one more transaction, then in_ready drops until out_ready returns.
//   bank registers update as a register write leaves the input register.
//   reset: config registers clear to zero, rom bank to one, other bank state
//   to zero, both pipeline stages empty.
`include "cartridge_bank_mapper_assert.svh"

module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [2:0]   mapper_kind_reg;
    logic [3:0]   rom_size_code_reg;
    logic [1:0]   ram_size_code_reg;

    logic [8:0]   rom_bank_reg;
    logic [8:0]   rom_bank_next;
    logic [3:0]   ram_bank_reg;
    logic [3:0]   ram_bank_next;
    logic         banking_mode_reg;
    logic         banking_mode_next;
    logic         ram_enabled_reg;
    logic         ram_enabled_next;

    logic         stage_valid_reg;
    in_item_t     stage_item_reg;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    out_item_t    result;

    logic         stage_adv;
    logic         reg_write_adv;
    mapper_kind_t kind;
    command_t     cmd;
    logic [14:0]  addr;
    logic [7:0]   din;
    logic [1:0]   top;
    logic [2:0]   quarter;
    logic         upper;
    logic         fitted;
    logic         enable_value;
    logic [8:0]   sel_bank;
    logic [3:0]   rom_code_sat;
    logic [23:0]  rom_span;
    logic [22:0]  rom_mask;
    logic [14:0]  ram_mask;
    logic [22:0]  rom_phys;
    logic [14:0]  ram_off;
    logic [14:0]  ram_banked;

    assign cfg_ready = 1'b1;
    assign stage_adv = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || stage_adv;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign kind = (mapper_kind_reg <= MK_MBC5) ? mapper_kind_t'(mapper_kind_reg) : MK_NONE;
    assign cmd  = command_t'(stage_item_reg.command);
    assign addr = stage_item_reg.address;
    assign din  = stage_item_reg.data;
    assign reg_write_adv = stage_adv && (cmd == CMD_REG_WRITE);

    assign top          = addr[14:13];
    assign quarter      = addr[14:12];
    assign upper        = addr[14];
    assign fitted       = (ram_size_code_reg != 2'd0);
    assign enable_value = (din[3:0] == ENABLE_NIBBLE);

    assign rom_code_sat = (rom_size_code_reg > ROM_CODE_MAX) ? ROM_CODE_MAX : rom_size_code_reg;
    assign rom_span     = 24'h008000 << rom_code_sat;
    assign rom_mask     = 23'(rom_span - 24'd1);

    always_comb
    begin
        case (ram_size_code_reg)
            2'd0:    ram_mask = 15'h0000;
            2'd1:    ram_mask = 15'h07FF;
            2'd2:    ram_mask = 15'h1FFF;
            default: ram_mask = 15'h7FFF;
        endcase
    end

    // bank register writes
    always_comb
    begin
        rom_bank_next     = rom_bank_reg;
        ram_bank_next     = ram_bank_reg;
        banking_mode_next = banking_mode_reg;
        ram_enabled_next  = ram_enabled_reg;
        sel_bank          = (kind == MK_MBC3) ? {2'b00, din[6:0]} : {4'b0000, din[4:0]};
        if (reg_write_adv)
        begin
            case (kind)
                MK_MBC1, MK_MBC1M, MK_MBC3:
                begin
                    case (top)
                        2'd0:
                        begin
                            if (fitted)
                            begin
                                ram_enabled_next = enable_value;
                            end
                        end
                        2'd1:
                        begin
                            rom_bank_next = (sel_bank == 9'd0) ? ROM_BANK_RESET : sel_bank;
                        end
                        2'd2:
                        begin
                            ram_bank_next = (kind == MK_MBC3) ? din[3:0] : {2'b00, din[1:0]};
                        end
                        default:
                        begin
                            if (kind != MK_MBC3)
                            begin
                                banking_mode_next = din[0];
                            end
                        end
                    endcase
                end
                MK_MBC2:
                begin
                    if (!upper)
                    begin
                        if (addr[8])
                        begin
                            rom_bank_next = (din[3:0] == 4'd0) ? ROM_BANK_RESET
                                                               : {5'd0, din[3:0]};
                        end
                        else
                        begin
                            ram_enabled_next = enable_value;
                        end
                    end
                end
                MK_MBC5:
                begin
                    case (quarter)
                        3'd0, 3'd1:
                        begin
                            if (fitted)
                            begin
                                ram_enabled_next = enable_value;
                            end
                        end
                        3'd2:    rom_bank_next = {rom_bank_reg[8], din};
                        3'd3:    rom_bank_next = {din[0], rom_bank_reg[7:0]};
                        3'd4, 3'd5: ram_bank_next = din[3:0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // address translation
    always_comb
    begin
        rom_phys = {9'd0, addr[13:0]};
        case (kind)
            MK_MBC1:
            begin
                if (upper)
                begin
                    rom_phys = rom_phys | 23'({rom_bank_reg[4:0], 14'd0})
                                        | 23'({ram_bank_reg[1:0], 19'd0});
                end
                else if (banking_mode_reg)
                begin
                    rom_phys = rom_phys | 23'({ram_bank_reg[1:0], 19'd0});
                end
            end
            MK_MBC1M:
            begin
                if (upper)
                begin
                    rom_phys = rom_phys | 23'({rom_bank_reg[3:0], 14'd0})
                                        | 23'({ram_bank_reg[1:0], 18'd0});
                end
                else if (banking_mode_reg)
                begin
                    rom_phys = rom_phys | 23'({ram_bank_reg[1:0], 18'd0});
                end
            end
            MK_MBC2:
            begin
                if (upper)
                begin
                    rom_phys = rom_phys | 23'({rom_bank_reg[3:0], 14'd0});
                end
            end
            MK_MBC3:
            begin
                if (upper)
                begin
                    rom_phys = rom_phys | 23'({rom_bank_reg[6:0], 14'd0});
                end
            end
            MK_MBC5:
            begin
                if (upper)
                begin
                    rom_phys = rom_phys | {rom_bank_reg, 14'd0};
                end
            end
            default: rom_phys = {8'd0, addr};
        endcase
        rom_phys = rom_phys & rom_mask;
    end

    assign ram_off    = {2'b00, addr[12:0]};
    assign ram_banked = ram_off | {ram_bank_reg[1:0], 13'd0};

    always_comb
    begin
        result = '0;
        case (cmd)
            CMD_REG_WRITE: ;
            CMD_ROM_READ:  result.rom_address = rom_phys;
            default:
            begin
                result.write_data = din;
                case (kind)
                    MK_MBC2:
                    begin
                        result.write_data = din | MBC2_DATA_ONES;
                        if (ram_enabled_reg)
                        begin
                            result.ram_select  = 1'b1;
                            result.ram_address = {6'd0, ram_off[8:0]};
                        end
                    end
                    MK_MBC1, MK_MBC1M:
                    begin
                        if (ram_enabled_reg && fitted)
                        begin
                            result.ram_select  = 1'b1;
                            result.ram_address = (banking_mode_reg ? ram_banked : ram_off)
                                                 & ram_mask;
                        end
                    end
                    MK_MBC3:
                    begin
                        if (ram_enabled_reg && fitted && (ram_bank_reg < MBC3_RAM_BANKS))
                        begin
                            result.ram_select  = 1'b1;
                            result.ram_address = ram_banked & ram_mask;
                        end
                    end
                    MK_MBC5:
                    begin
                        if (ram_enabled_reg && fitted)
                        begin
                            result.ram_select  = 1'b1;
                            result.ram_address = ram_banked & ram_mask;
                        end
                    end
                    default: ;
                endcase
                if (cmd == CMD_RAM_WRITE)
                begin
                    result.ram_write_strobe = result.ram_select;
                end
                else if (!result.ram_select)
                begin
                    result.read_or_mask = OPEN_BUS_MASK;
                end
                else if (kind == MK_MBC2)
                begin
                    result.read_or_mask = MBC2_DATA_ONES;
                end
            end
        endcase
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_kind_reg   <= '0;
            rom_size_code_reg <= '0;
            ram_size_code_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAPPER_KIND:   mapper_kind_reg   <= cfg_data[2:0];
                CFG_ROM_SIZE_CODE: rom_size_code_reg <= cfg_data[3:0];
                CFG_RAM_SIZE_CODE: ram_size_code_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // bank state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg     <= ROM_BANK_RESET;
            ram_bank_reg     <= '0;
            banking_mode_reg <= 1'b0;
            ram_enabled_reg  <= 1'b0;
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rom_bank_reg     <= rom_bank_next;
            ram_bank_reg     <= ram_bank_next;
            banking_mode_reg <= banking_mode_next;
            ram_enabled_reg  <= ram_enabled_next;
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (stage_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_item;
        end
        if (stage_adv)
        begin
            out_item_reg <= result;
        end
    end

    `CBM_ASSERT_RUN(a_accept_fills_stage, in_valid && in_ready |=> stage_valid_reg,
        "accepted transaction lost before the input register")
    `CBM_ASSERT_RUN(a_adv_fills_output, stage_adv |=> out_valid_reg,
        "advanced transaction did not reach the result register")
    `CBM_ASSERT_RUN(a_bank_stable,
        !reg_write_adv |=> $stable(rom_bank_reg) && $stable(ram_bank_reg)
            && $stable(ram_enabled_reg),
        "bank state changed without a register write")
    `CBM_ASSERT_ALWAYS(a_strobe_needs_select,
        out_valid_reg && out_item_reg.ram_write_strobe |-> out_item_reg.ram_select,
        "ram write strobe without ram select")
    `CBM_ASSERT_ALWAYS(a_select_no_rom,
        out_valid_reg && out_item_reg.ram_select |-> out_item_reg.rom_address == 23'd0,
        "ram access also drove a rom address")

endmodule
